// File: hdl/svpwm_duty_from_uq_macros.svh
// ---------------------------------------------------------------------------
// svpwm_duty_from_uq macros
// assertion helpers used by the svpwm_duty_from_uq top level
// ---------------------------------------------------------------------------
`ifndef SVPWM_DUTY_FROM_UQ_MACROS_SVH
`define SVPWM_DUTY_FROM_UQ_MACROS_SVH

// same-cycle implication, disabled in reset
`define SVPWM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SVPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/svpwm_pkg.sv
// ---------------------------------------------------------------------------
// svpwm_pkg
// shared types and constants of the svpwm duty pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package svpwm_pkg;

  // register map, one register per 32-bit word
  typedef enum logic [1:0] {
    REG_UQ_LIMIT       = 2'd0,
    REG_MAX_VOLTAGE    = 2'd1,
    REG_SUPPLY_VOLTAGE = 2'd2,
    REG_PWM_PERIOD     = 2'd3
  } svpwm_reg_t;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  localparam logic [14:0] RstUqLimit       = 15'd0;
  localparam logic [14:0] RstMaxVoltage    = 15'd3072;
  localparam logic [14:0] RstSupplyVoltage = 15'd3072;
  localparam logic [15:0] RstPwmPeriod     = 16'd4199;

  // sqrt(3) in q2.30
  localparam logic signed [31:0] Sqrt3Q30 = 32'sd1859775393;

  // quotient bits of the duty divider, one per stage
  localparam int DivSteps = 16;

  typedef struct packed {
    logic signed [15:0] uq_volts;
    logic signed [15:0] sin_angle;
    logic signed [15:0] cos_angle;
  } svpwm_in_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
  } svpwm_out_t;

  // live configuration seen by the datapath
  typedef struct packed {
    logic [14:0] lim;     // effective q voltage limit
    logic [14:0] supply;
    logic [15:0] period;
  } svpwm_cfg_t;

  // per-phase dividends, already divided by 2^17
  typedef struct packed {
    logic [31:0] num_a;
    logic [31:0] num_b;
    logic [31:0] num_c;
  } svpwm_num_t;

endpackage

// File: hdl/svpwm_duty_from_uq.sv
// ---------------------------------------------------------------------------
// svpwm_duty_from_uq
// q-axis voltage to three space-vector pwm compare values
// ---------------------------------------------------------------------------
// Takes one item per clock while in_ready is high: a signed q voltage
// (1/256 V) with the sine and cosine of the electrical angle (q1.15), and
// returns three timer compare values in [0, pwm_period]. Throughput is one
// item per cycle unless out_ready holds the pipe. The result passes the
// eight transform stages plus the sixteen stages of the restoring divider,
// which produces one quotient bit per stage. Each stage moves forward
// whenever its successor has room, so empty stages keep filling while a
// finished result waits at the output. Registers (apb, 32-bit words): 0x0
// q voltage limit, 0x4 max_voltage, 0x8 supply_voltage, 0xc pwm_period.
// Write them only while no items are in flight. A zero supply_voltage
// forces every duty to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "svpwm_duty_from_uq_macros.svh"

module svpwm_duty_from_uq
  import svpwm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  svpwm_in_t           in_data,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output svpwm_out_t          out_data,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  svpwm_cfg_t cfg_bus;
  svpwm_num_t num;
  logic       num_valid;
  logic       num_ready;

  // no wait states on the register port
  assign cfg_pready = 1'b1;

  // register file, also picks the effective voltage limit
  svpwm_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg_bus)
  );

  // clamp, inverse transforms, min/max injection and period scaling
  svpwm_transform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_bus),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (num_valid),
    .out_ready (num_ready),
    .out_num   (num)
  );

  // divide by the supply, rounding already folded into the dividend
  svpwm_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_bus),
    .in_valid  (num_valid),
    .in_ready  (num_ready),
    .in_num    (num),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // with the output slot free or draining, the whole pipe can take an item
  `SVPWM_ASSERT_SAME(a_ready_chain, clk, rst_n, (!out_valid || out_ready), in_ready, "in_ready low with output free")

  // zero supply must give zero duties
  `SVPWM_ASSERT_SAME(a_zero_supply, clk, rst_n, (out_valid && (cfg_bus.supply == '0)), ((out_data.duty_a == '0) && (out_data.duty_b == '0) && (out_data.duty_c == '0)), "nonzero duty with zero supply")

  // a supply write lands in the datapath configuration
  `SVPWM_ASSERT_NEXT(a_supply_write, clk, rst_n, (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[3:2] == REG_SUPPLY_VOLTAGE)), (cfg_bus.supply == $past(cfg_pwdata[14:0])), "supply write lost")

endmodule

// File: hdl/svpwm_cfg_regs.sv
// ---------------------------------------------------------------------------
// svpwm_cfg_regs
// apb register file and voltage limit selection
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svpwm_cfg_regs
  import svpwm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output svpwm_cfg_t          cfg
);

  logic [14:0] vlim_r, vlim_nxt;
  logic [14:0] vmax_r, vmax_nxt;
  logic [14:0] supply_r, supply_nxt;
  logic [15:0] period_r, period_nxt;
  logic        wr_en;
  svpwm_reg_t  idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = svpwm_reg_t'(paddr[3:2]);

  always_comb begin
    vlim_nxt   = vlim_r;
    vmax_nxt   = vmax_r;
    supply_nxt = supply_r;
    period_nxt = period_r;
    if (wr_en) begin
      case (idx)
        REG_UQ_LIMIT:       vlim_nxt   = pwdata[14:0];
        REG_MAX_VOLTAGE:    vmax_nxt   = pwdata[14:0];
        REG_SUPPLY_VOLTAGE: supply_nxt = pwdata[14:0];
        REG_PWM_PERIOD:     period_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r   <= RstUqLimit;
      vmax_r   <= RstMaxVoltage;
      supply_r <= RstSupplyVoltage;
      period_r <= RstPwmPeriod;
    end else begin
      vlim_r   <= vlim_nxt;
      vmax_r   <= vmax_nxt;
      supply_r <= supply_nxt;
      period_r <= period_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_UQ_LIMIT:       prdata = {17'd0, vlim_r};
      REG_MAX_VOLTAGE:    prdata = {17'd0, vmax_r};
      REG_SUPPLY_VOLTAGE: prdata = {17'd0, supply_r};
      REG_PWM_PERIOD:     prdata = {16'd0, period_r};
      default:            prdata = '0;
    endcase
  end

  // zero or oversized limit falls back to the ceiling
  assign cfg.lim    = ((vlim_r == '0) || (vlim_r > vmax_r)) ? vmax_r : vlim_r;
  assign cfg.supply = supply_r;
  assign cfg.period = period_r;

endmodule

// File: hdl/svpwm_transform.sv
// ---------------------------------------------------------------------------
// svpwm_transform
// clamp, inverse park/clarke, zero sequence and duty scaling, eight stages
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svpwm_transform
  import svpwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  svpwm_cfg_t cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  svpwm_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output svpwm_num_t out_num
);

  localparam int NumStages = 8;
  localparam int PW = 36;

  logic [NumStages-1:0] v_r;
  logic [NumStages-1:0] vin;
  logic [NumStages-1:0] load;
  logic [NumStages:0]   rdy;

  assign rdy[NumStages] = out_ready;
  assign vin = {v_r[NumStages-2:0], in_valid};

  genvar k;
  generate
    for (k = 0; k < NumStages; k++) begin : g_ctl
      assign rdy[k]  = !v_r[k] || rdy[k+1];
      assign load[k] = rdy[k] && vin[k];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NumStages; i++) begin
        if (rdy[i]) v_r[i] <= vin[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NumStages-1];

  // stage 1: clamp uq and form alpha/beta products
  logic signed [15:0] lim_s, uq_c;
  logic signed [31:0] prod_s, s1_ualpha_nxt, s1_ubeta_nxt;
  logic signed [31:0] s1_ualpha_r, s1_ubeta_r;

  always_comb begin
    lim_s = $signed({1'b0, cfg.lim});
    if (in_data.uq_volts > lim_s) begin
      uq_c = lim_s;
    end else if (in_data.uq_volts < -lim_s) begin
      uq_c = -lim_s;
    end else begin
      uq_c = in_data.uq_volts;
    end
    prod_s        = uq_c * in_data.sin_angle;
    s1_ualpha_nxt = -prod_s;
    s1_ubeta_nxt  = uq_c * in_data.cos_angle;
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_ualpha_r <= s1_ualpha_nxt;
      s1_ubeta_r  <= s1_ubeta_nxt;
    end
  end

  // stage 2: sqrt(3) * ubeta
  logic signed [62:0] s2_x_nxt, s2_x_r;
  logic signed [31:0] s2_ualpha_r;

  assign s2_x_nxt = s1_ubeta_r * Sqrt3Q30;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_x_r      <= s2_x_nxt;
      s2_ualpha_r <= s1_ualpha_r;
    end
  end

  // stage 3: drop 30 fraction bits, round half away from zero
  logic signed [62:0] rnd_add, rnd_sum, rnd_shr;
  logic signed [31:0] s3_t_nxt, s3_t_r, s3_ualpha_r;

  always_comb begin
    rnd_add  = s2_x_r[62] ? 63'sd536870911 : 63'sd536870912;
    rnd_sum  = s2_x_r + rnd_add;
    rnd_shr  = rnd_sum >>> 30;
    s3_t_nxt = rnd_shr[31:0];
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_t_r      <= s3_t_nxt;
      s3_ualpha_r <= s2_ualpha_r;
    end
  end

  // stage 4: phase voltages at four times scale
  logic signed [PW-1:0] ua_w, t_w;
  logic signed [PW-1:0] s4_pa_nxt, s4_pb_nxt, s4_pc_nxt;
  logic signed [PW-1:0] s4_pa_r, s4_pb_r, s4_pc_r;

  always_comb begin
    ua_w      = $signed({{(PW-32){s3_ualpha_r[31]}}, s3_ualpha_r});
    t_w       = $signed({{(PW-32){s3_t_r[31]}}, s3_t_r});
    s4_pa_nxt = ua_w <<< 2;
    s4_pb_nxt = (t_w - ua_w) <<< 1;
    s4_pc_nxt = -((t_w + ua_w) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_pa_r <= s4_pa_nxt;
      s4_pb_r <= s4_pb_nxt;
      s4_pc_r <= s4_pc_nxt;
    end
  end

  // stage 5: max and min of the three phases
  logic signed [PW-1:0] hab, lab, s5_hi_nxt, s5_lo_nxt;
  logic signed [PW-1:0] s5_hi_r, s5_lo_r, s5_pa_r, s5_pb_r, s5_pc_r;

  always_comb begin
    hab       = (s4_pb_r > s4_pa_r) ? s4_pb_r : s4_pa_r;
    lab       = (s4_pb_r < s4_pa_r) ? s4_pb_r : s4_pa_r;
    s5_hi_nxt = (s4_pc_r > hab) ? s4_pc_r : hab;
    s5_lo_nxt = (s4_pc_r < lab) ? s4_pc_r : lab;
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s5_hi_r <= s5_hi_nxt;
      s5_lo_r <= s5_lo_nxt;
      s5_pa_r <= s4_pa_r;
      s5_pb_r <= s4_pb_r;
      s5_pc_r <= s4_pc_r;
    end
  end

  // stage 6: zero sequence, hi + lo is always even
  logic signed [PW-1:0] half_full, hl_sum, s6_zero_nxt;
  logic signed [PW-1:0] s6_zero_r, s6_pa_r, s6_pb_r, s6_pc_r;

  always_comb begin
    half_full   = $signed({{(PW-31){1'b0}}, cfg.supply, 16'd0});
    hl_sum      = s5_hi_r + s5_lo_r;
    s6_zero_nxt = half_full - (hl_sum >>> 1);
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s6_zero_r <= s6_zero_nxt;
      s6_pa_r   <= s5_pa_r;
      s6_pb_r   <= s5_pb_r;
      s6_pc_r   <= s5_pc_r;
    end
  end

  // stage 7: shift by zero sequence, clamp to [0, full]
  logic signed [PW-1:0] full_s, qa, qb, qc;
  logic [32:0] s7_pa_nxt, s7_pb_nxt, s7_pc_nxt;
  logic [32:0] s7_pa_r, s7_pb_r, s7_pc_r;

  function automatic logic [32:0] clamp_full(input logic signed [PW-1:0] x,
                                             input logic signed [PW-1:0] hi);
    logic [32:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > hi) begin
      res = hi[32:0];
    end else begin
      res = x[32:0];
    end
    return res;
  endfunction

  always_comb begin
    full_s    = $signed({{(PW-32){1'b0}}, cfg.supply, 17'd0});
    qa        = s6_pa_r + s6_zero_r;
    qb        = s6_pb_r + s6_zero_r;
    qc        = s6_pc_r + s6_zero_r;
    s7_pa_nxt = clamp_full(qa, full_s);
    s7_pb_nxt = clamp_full(qb, full_s);
    s7_pc_nxt = clamp_full(qc, full_s);
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      s7_pa_r <= s7_pa_nxt;
      s7_pb_r <= s7_pb_nxt;
      s7_pc_r <= s7_pc_nxt;
    end
  end

  // stage 8: phase * period + full/2, then drop the 2^17 of the supply scale
  logic [48:0] half_u, na, nb, nc;
  svpwm_num_t  s8_num_nxt, s8_num_r;

  always_comb begin
    half_u           = {18'd0, cfg.supply, 16'd0};
    na               = s7_pa_r * cfg.period + half_u;
    nb               = s7_pb_r * cfg.period + half_u;
    nc               = s7_pc_r * cfg.period + half_u;
    s8_num_nxt.num_a = na[48:17];
    s8_num_nxt.num_b = nb[48:17];
    s8_num_nxt.num_c = nc[48:17];
  end

  always_ff @(posedge clk) begin
    if (load[7]) s8_num_r <= s8_num_nxt;
  end

  assign out_num = s8_num_r;

endmodule

// File: hdl/svpwm_divider.sv
// ---------------------------------------------------------------------------
// svpwm_divider
// pipelined restoring divide by supply_voltage, one quotient bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svpwm_divider
  import svpwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  svpwm_cfg_t cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  svpwm_num_t in_num,
  output logic       out_valid,
  input  logic       out_ready,
  output svpwm_out_t out_data
);

  logic [DivSteps-1:0] v_r;
  logic [DivSteps-1:0] vin;
  logic [DivSteps-1:0] load;
  logic [DivSteps:0]   rdy;

  // remainder is not needed after the last stage
  logic [31:0] rem_r [DivSteps-1][3];
  logic [15:0] quo_r [DivSteps][3];

  assign rdy[DivSteps] = out_ready;
  assign vin = {v_r[DivSteps-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < DivSteps; i++) begin
        if (rdy[i]) v_r[i] <= vin[i];
      end
    end
  end

  genvar k, p;
  generate
    for (k = 0; k < DivSteps; k++) begin : g_stage
      assign rdy[k]  = !v_r[k] || rdy[k+1];
      assign load[k] = rdy[k] && vin[k];

      for (p = 0; p < 3; p++) begin : g_phase
        logic [31:0] rem_in, dsh, rem_nxt;
        logic [15:0] quo_in, quo_nxt;
        logic        ge;

        if (k == 0) begin : g_first
          assign rem_in = (p == 0) ? in_num.num_a :
                          (p == 1) ? in_num.num_b : in_num.num_c;
          assign quo_in = '0;
        end else begin : g_next
          assign rem_in = rem_r[k-1][p];
          assign quo_in = quo_r[k-1][p];
        end

        always_comb begin
          dsh     = {17'd0, cfg.supply} << (DivSteps - 1 - k);
          ge      = (rem_in >= dsh);
          rem_nxt = ge ? (rem_in - dsh) : rem_in;
          quo_nxt = quo_in;
          quo_nxt[DivSteps-1-k] = ge;
        end

        always_ff @(posedge clk) begin
          if (load[k]) quo_r[k][p] <= quo_nxt;
        end

        if (k < DivSteps - 1) begin : g_rem
          always_ff @(posedge clk) begin
            if (load[k]) rem_r[k][p] <= rem_nxt;
          end
        end
      end
    end
  endgenerate

  // a zero supply gives zero duty on every phase
  logic supply_zero;
  assign supply_zero = (cfg.supply == '0);

  assign in_ready        = rdy[0];
  assign out_valid       = v_r[DivSteps-1];
  assign out_data.duty_a = supply_zero ? '0 : quo_r[DivSteps-1][0];
  assign out_data.duty_b = supply_zero ? '0 : quo_r[DivSteps-1][1];
  assign out_data.duty_c = supply_zero ? '0 : quo_r[DivSteps-1][2];

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the svpwm duty pipeline
// ---------------------------------------------------------------------------
// Walks a short table of directed items under the reset settings, then runs
// random items through nine register settings: defaults, limit selection,
// zero max voltage, zero supply, zero period and full-range extremes. Each
// accepted item's compare values, from the table or from a local fixed-point
// model of the modulator, are queued. Every accepted result is checked
// field by field against the oldest queued prediction.
// ---------------------------------------------------------------------------

module tb;
  import svpwm_pkg::*;

  localparam int ClkHalf    = 5;
  localparam int RstCycles  = 6;
  localparam int NumPhases  = 9;
  localparam int PhaseItems = 205;
  localparam int NumRows    = 20;
  localparam int HoldCycles = 200;   // long receiver hold-off
  localparam int StallLimit = 4000;  // cycles with no handshake at all
  localparam int TailCycles = 40;    // pipeline is 24 stages deep

  // one directed row; typed rows carry their compare values
  typedef struct packed {
    logic [15:0] uq;
    logic [15:0] sn;
    logic [15:0] cs;
    logic        typed;
    logic [15:0] da;
    logic [15:0] db;
    logic [15:0] dc;
  } duty_row_t;

  // register values for one phase of the run
  typedef struct packed {
    logic [31:0] vlim;
    logic [31:0] vmax;
    logic [31:0] supply;
    logic [31:0] period;
  } reg_set_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  svpwm_in_t           in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  svpwm_out_t          out_data;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr   = '0;
  logic [CfgDataW-1:0] cfg_pwdata  = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  // local copy of the register file, as the model sees it
  longint m_vlim   = RstUqLimit;
  longint m_vmax   = RstMaxVoltage;
  longint m_supply = RstSupplyVoltage;
  longint m_period = RstPwmPeriod;

  svpwm_out_t duty_q [$];   // predicted compare values, oldest first
  int         n_fail      = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         hold_req    = 0;
  int         hold_done   = 0;
  int         hold_left   = 0;
  int         stall_cnt   = 0;

  svpwm_duty_from_uq u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #ClkHalf clk = ~clk;

  // effective q voltage limit under the current registers
  function automatic longint eff_limit();
    return (m_vlim == 0 || m_vlim > m_vmax) ? m_vmax : m_vlim;
  endfunction

  // compare value for one phase held at four times its voltage
  function automatic logic [15:0] phase_to_duty(longint ph, longint full);
    longint q;
    if (full <= 0) return 16'd0;
    q = (ph * m_period + full / 2) / full;
    return q[15:0];
  endfunction

  // uq, sin, cos -> three compare values, min/max zero-sequence svpwm
  function automatic svpwm_out_t predict_duty(svpwm_in_t d);
    longint     uq, sn, cs, lim, ualpha, ubeta, prod, t;
    longint     pa, pb, pc, hi, lo, full, zero;
    svpwm_out_t r;
    uq  = longint'(signed'(d.uq_volts));
    sn  = longint'(signed'(d.sin_angle));
    cs  = longint'(signed'(d.cos_angle));
    lim = eff_limit();
    if (uq > lim) uq = lim;
    if (uq < -lim) uq = -lim;
    // inverse park with ud = 0, products kept exact
    ualpha = -(uq * sn);
    ubeta  = uq * cs;
    // sqrt(3) * ubeta, q30 product rounded half away from zero
    prod = ubeta * longint'(Sqrt3Q30);
    if (prod < 0) t = -(((-prod) + (64'sd1 <<< 29)) >>> 30);
    else t = (prod + (64'sd1 <<< 29)) >>> 30;
    // inverse clarke at 4x scale so every halving stays exact
    pa = 4 * ualpha;
    pb = 2 * (t - ualpha);
    pc = -2 * (t + ualpha);
    hi = pa;
    lo = pa;
    if (pb > hi) hi = pb;
    if (pc > hi) hi = pc;
    if (pb < lo) lo = pb;
    if (pc < lo) lo = pc;
    // centre the phases on half the supply, then clamp to the rails
    full = m_supply * 131072;
    zero = full / 2 - (hi + lo) / 2;
    pa = pa + zero;
    pb = pb + zero;
    pc = pc + zero;
    if (pa < 0) pa = 0;
    if (pb < 0) pb = 0;
    if (pc < 0) pc = 0;
    if (pa > full) pa = full;
    if (pb > full) pb = full;
    if (pc > full) pc = full;
    r.duty_a = phase_to_duty(pa, full);
    r.duty_b = phase_to_duty(pb, full);
    r.duty_c = phase_to_duty(pc, full);
    return r;
  endfunction

  // mostly unit-circle angles with uq around the limit, plus raw noise
  function automatic svpwm_in_t make_random_item();
    svpwm_in_t d;
    real       ang, amp;
    int        lim, span, pick, v;
    lim  = int'(eff_limit());
    span = lim + lim / 8 + 2;
    pick = $urandom_range(99);
    if (pick < 65) begin
      ang = 6.283185307 * real'($urandom_range(65535)) / 65536.0;
      amp = (pick < 50) ? 32767.0 : real'($urandom_range(32767));
      d.sin_angle = 16'($rtoi(amp * $sin(ang)));
      d.cos_angle = 16'($rtoi(amp * $cos(ang)));
    end else begin
      d.sin_angle = 16'($urandom_range(65535));
      d.cos_angle = 16'($urandom_range(65535));
    end
    pick = $urandom_range(99);
    if (pick < 35) begin
      v = int'($urandom_range(65535)) - 32768;
    end else if (pick < 80) begin
      v = int'($urandom_range(2 * span)) - span;
    end else begin
      case ($urandom_range(6))
        0:       v = -32768;
        1:       v = 32767;
        2:       v = lim;
        3:       v = -lim;
        4:       v = lim + 1;
        5:       v = -lim - 1;
        default: v = 0;
      endcase
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    d.uq_volts = 16'(v);
    return d;
  endfunction

  // apb write: setup, access, then the bus is released and left idle before returning
  task automatic cfg_write(input svpwm_reg_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_UQ_LIMIT:       m_vlim   = longint'(val & 32'h7FFF);
      REG_MAX_VOLTAGE:    m_vmax   = longint'(val & 32'h7FFF);
      REG_SUPPLY_VOLTAGE: m_supply = longint'(val & 32'h7FFF);
      REG_PWM_PERIOD:     m_period = longint'(val & 32'hFFFF);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one item, queue its prediction once accepted
  task automatic send_item(input svpwm_in_t d, input svpwm_out_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    duty_q.push_back(want);
  endtask

  // stop offering until every queued prediction has been matched
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (duty_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker, oldest prediction first
  always @(posedge clk) begin : result_check
    svpwm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (duty_q.size() == 0) begin
        $display("%0t unexpected item: expected none, got a=%0d b=%0d c=%0d",
                 $time, out_data.duty_a, out_data.duty_b, out_data.duty_c);
        n_fail++;
      end else begin
        want = duty_q.pop_front();
        if (out_data.duty_a !== want.duty_a) begin
          $display("%0t duty_a mismatch: expected %0d, got %0d",
                   $time, want.duty_a, out_data.duty_a);
          n_fail++;
        end
        if (out_data.duty_b !== want.duty_b) begin
          $display("%0t duty_b mismatch: expected %0d, got %0d",
                   $time, want.duty_b, out_data.duty_b);
          n_fail++;
        end
        if (out_data.duty_c !== want.duty_c) begin
          $display("%0t duty_c mismatch: expected %0d, got %0d",
                   $time, want.duty_c, out_data.duty_c);
          n_fail++;
        end
      end
    end
  end

  // watchdog: any handshake on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("%0t timeout, %0d items still expected", $time, duty_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : stimulus
    duty_row_t  rows [0:NumRows-1];
    reg_set_t   sets [0:NumPhases-1];
    svpwm_in_t  d;
    svpwm_out_t want;
    int         ph, n;

    // directed items under reset settings; with uq or both trig terms at
    // zero every phase sits at half supply, i.e. round(4199 / 2) = 2100
    rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd2100, 16'd2100, 16'd2100},
      '{16'h7FFF, 16'h0000, 16'h0000, 1'b1, 16'd2100, 16'd2100, 16'd2100},
      '{16'h8000, 16'h0000, 16'h0000, 1'b1, 16'd2100, 16'd2100, 16'd2100},
      '{16'h0000, 16'h7FFF, 16'h8000, 1'b1, 16'd2100, 16'd2100, 16'd2100},
      '{16'h0000, 16'h8000, 16'h7FFF, 1'b1, 16'd2100, 16'd2100, 16'd2100},
      // full-scale trig values with uq clamped hard to the limit
      '{16'h7FFF, 16'h7FFF, 16'h0000, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'h7FFF, 16'h8000, 16'h0000, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'h7FFF, 16'h0000, 16'h7FFF, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'h7FFF, 16'h0000, 16'h8000, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, 16'd0, 16'd0, 16'd0},
      // uq right at the limit and one step past it, both signs
      '{16'h0C00, 16'h0000, 16'h7FFF, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'h0C01, 16'h5A82, 16'h5A82, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'hF3FF, 16'hA57E, 16'h5A82, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'hF400, 16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0, 16'd0},
      // smallest nonzero products, rounding of the sqrt(3) term
      '{16'hFFFF, 16'h0001, 16'h0001, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'h0001, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0},
      // alternating bit patterns, then one mid-range item
      '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 16'd0, 16'd0, 16'd0},
      '{16'h0600, 16'h4000, 16'h9127, 1'b0, 16'd0, 16'd0, 16'd0}
    };

    // phase settings; the first row stands for the reset values
    sets = '{
      '{32'd0,        32'd3072,  32'd3072,  32'd4199},
      '{32'd1000,     32'd3072,  32'd3072,  32'd4199},   // limit below max
      '{32'd5000,     32'd3072,  32'd32767, 32'd65535},  // limit above max, top supply/period
      '{32'd32767,    32'd32767, 32'd1,     32'd1},      // widest limit, tiny supply/period
      '{32'd0,        32'd0,     32'd2000,  32'd1000},   // zero max voltage forces uq to 0
      '{32'd200,      32'd500,   32'd0,     32'd4199},   // zero supply, all duties 0
      '{32'd0,        32'd32767, 32'd3072,  32'd0},      // zero period, all duties 0
      '{32'd12000,    32'd16000, 32'd12000, 32'd20000},
      '{32'h0001_7FFF, 32'd24000, 32'd24000, 32'd8399}   // upper bits dropped on write
    };

    repeat (RstCycles) @(posedge clk);
    rst_n       <= 1'b1;
    tx_idle_pct <= 14;
    rx_idle_pct <= 60;
    @(posedge clk);

    for (n = 0; n < NumRows; n++) begin
      d.uq_volts  = rows[n].uq;
      d.sin_angle = rows[n].sn;
      d.cos_angle = rows[n].cs;
      if (rows[n].typed) want = {rows[n].da, rows[n].db, rows[n].dc};
      else want = predict_duty(d);
      send_item(d, want);
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      // sender-light/receiver-heavy, then the reverse, then no idling
      if (ph < 3) begin
        tx_idle_pct <= 14;
        rx_idle_pct <= 60;
      end else if (ph < 6) begin
        tx_idle_pct <= 60;
        rx_idle_pct <= 14;
      end else begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      // registers change only with the pipeline empty
      if (ph != 0) begin
        wait_drained();
        cfg_write(REG_UQ_LIMIT, sets[ph].vlim);
        cfg_write(REG_MAX_VOLTAGE, sets[ph].vmax);
        cfg_write(REG_SUPPLY_VOLTAGE, sets[ph].supply);
        cfg_write(REG_PWM_PERIOD, sets[ph].period);
      end
      for (n = 0; n < PhaseItems; n++) begin
        // receiver stops for a long stretch while items keep coming, so
        // the pipeline fills and in_ready drops
        if (ph == 0 && n == 60) hold_req <= hold_req + 1;
        // mid-phase pause until every result is back
        if (ph == 7 && n == 100) wait_drained();
        d = make_random_item();
        send_item(d, predict_duty(d));
      end
    end

    in_valid <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
